// File: src/gpioc_pkg.sv
// ----------------------------------------------------------------------------
// gpioc_pkg
// Shared types, register map and ID bytes of the eight-line GPIO controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gpioc_pkg;

  localparam int unsigned LineCount = 8;

  typedef enum logic [1:0] {
    ReqRead  = 2'd0,
    ReqWrite = 2'd1,
    ReqPin   = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  // Register map as word addresses (byte offset bits [11:2])
  localparam logic [9:0] WordDir     = 10'h100;
  localparam logic [9:0] WordSense   = 10'h101;
  localparam logic [9:0] WordBoth    = 10'h102;
  localparam logic [9:0] WordEvent   = 10'h103;
  localparam logic [9:0] WordMask    = 10'h104;
  localparam logic [9:0] WordRaw     = 10'h105;
  localparam logic [9:0] WordMasked  = 10'h106;
  localparam logic [9:0] WordClear   = 10'h107;
  localparam logic [9:0] WordAltFunc = 10'h108;
  localparam logic [9:0] WordPadLo   = 10'h140;
  localparam logic [9:0] WordPadHi   = 10'h147;
  localparam logic [9:0] WordLock    = 10'h148;
  localparam logic [9:0] WordCommit  = 10'h149;
  localparam logic [9:0] WordAnalog  = 10'h14A;
  localparam logic [9:0] WordIdBase  = 10'h3F4;

  localparam logic [31:0] UnlockKey = 32'h0ACC_E551;

  localparam logic [LineCount-1:0] PadDrv2mReset = '1;
  localparam logic [LineCount-1:0] CommitReset   = '1;

  function automatic logic [7:0] id_byte(input logic [3:0] idx);
    logic [7:0] val;
    unique case (idx)
      4'd4:    val = 8'h61;
      4'd5:    val = 8'h10;
      4'd6:    val = 8'h04;
      4'd8:    val = 8'h0D;
      4'd9:    val = 8'hF0;
      4'd10:   val = 8'h05;
      4'd11:   val = 8'hB1;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: src/gpio_controller_with_interrupts.sv
// ----------------------------------------------------------------------------
// gpio_controller_with_interrupts
// Eight-line GPIO controller: bus register file, pin event capture, edge and
// level interrupt detection with a combined interrupt output.
// ----------------------------------------------------------------------------
//  channel   direction  fields (low bit first)
//  s_axis    in         tuser: req_type; tdata: offset, write_data,
//                       pin_index, pin_level
//  m_axis    out        tuser: bus_error; tdata: read_data, out_pins, irq_line
//  cfg       in         cfg_wdata_i: input_invert, written when cfg_we_i
//
//  One transfer per cycle sustained while the result is not stalled; each
//  request passes the input register, then the result register.
//  All register state and the pending result clear on rst_ni low; pad entry
//  for 2 mA drive and commit reset to all ones, lock resets to locked.
//  A stalled result holds the result register and stalls the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_controller_with_interrupts
  import gpioc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,    // input_invert
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // offset[11:0], write_data[43:12],
                                           // pin_index[46:44], pin_level[47]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // read_data[7:0], out_pins[15:8],
                                           // irq_line[16], zero fill
  output logic [0:0]       m_axis_tuser    // bus_error[0]
);

  typedef logic [LineCount-1:0] lines_t;

  // Input register
  logic        in_valid_q;
  req_e        in_req_q;
  logic [11:0] in_off_q;
  logic [31:0] in_wdata_q;
  logic [2:0]  in_idx_q;
  logic        in_lvl_q;

  // Result register
  logic        out_valid_q;
  logic [7:0]  out_rdata_q;
  lines_t      out_pins_q;
  logic        out_irq_q;
  logic        out_err_q;

  // Controller state
  lines_t invert_q;
  lines_t pin_q, pin_d;
  lines_t drv_q, drv_d;
  lines_t smp_q, smp_d;
  lines_t dir_q, dir_d;
  lines_t sense_q, sense_d;
  lines_t both_q, both_d;
  lines_t pol_q, pol_d;
  lines_t en_q, en_d;
  lines_t raw_q, raw_d;
  lines_t alt_q, alt_d;
  lines_t pad_q [8];
  lines_t pad_d [8];
  lines_t analog_q, analog_d;
  logic   lock_q, lock_d;
  lines_t commit_q, commit_d;

  logic       advance;
  logic       proc;
  logic [9:0] word;
  lines_t     wbyte;
  lines_t     raw_clr;
  lines_t     drive;
  lines_t     moved;
  lines_t     match;
  logic       do_refresh;
  logic [7:0] rdata;
  logic       err;

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  assign word  = in_off_q[11:2];
  assign wbyte = in_wdata_q[LineCount-1:0];

  always_comb begin
    pin_d      = pin_q;
    dir_d      = dir_q;
    sense_d    = sense_q;
    both_d     = both_q;
    pol_d      = pol_q;
    en_d       = en_q;
    raw_clr    = raw_q;
    alt_d      = alt_q;
    pad_d      = pad_q;
    analog_d   = analog_q;
    lock_d     = lock_q;
    commit_d   = commit_q;
    do_refresh = 1'b0;
    rdata      = '0;
    err        = 1'b0;

    if (proc) begin
      unique case (in_req_q)
        ReqRead: begin
          priority if (word >= WordIdBase) begin
            rdata = id_byte(4'(word - WordIdBase));
          end else if (word[9:8] == 2'b00) begin
            rdata = pin_q & word[7:0];
          end else if (word >= WordPadLo && word <= WordPadHi) begin
            rdata = pad_q[word[2:0]];
          end else begin
            unique case (word)
              WordDir:     rdata = dir_q;
              WordSense:   rdata = sense_q;
              WordBoth:    rdata = both_q;
              WordEvent:   rdata = pol_q;
              WordMask:    rdata = en_q;
              WordRaw:     rdata = raw_q;
              WordMasked:  rdata = raw_q & en_q;
              WordAltFunc: rdata = alt_q;
              WordLock:    rdata = {7'd0, lock_q};
              WordCommit:  rdata = commit_q;
              WordAnalog:  rdata = analog_q;
              default:     err = 1'b1;
            endcase
          end
        end
        ReqWrite: begin
          priority if (word[9:8] == 2'b00) begin
            // Change output-direction bits selected by the address mask only
            pin_d = (pin_q & ~(word[7:0] & dir_q)) | (wbyte & word[7:0] & dir_q);
          end else if (word >= WordPadLo && word <= WordPadHi) begin
            pad_d[word[2:0]] = wbyte;
          end else begin
            unique case (word)
              WordDir:     dir_d = wbyte;
              WordSense:   sense_d = wbyte;
              WordBoth:    both_d = wbyte;
              WordEvent:   pol_d = wbyte;
              WordMask:    en_d = wbyte;
              WordClear:   raw_clr = raw_q & ~wbyte;
              WordAltFunc: alt_d = (alt_q & ~commit_q) | (wbyte & commit_q);
              WordLock:    lock_d = (in_wdata_q != UnlockKey);
              WordCommit:  commit_d = lock_q ? commit_q : wbyte;
              WordAnalog:  analog_d = wbyte;
              default:     err = 1'b1;
            endcase
          end
          do_refresh = !err;
        end
        ReqPin: begin
          // Ignore events on lines driven as outputs
          if (!dir_q[in_idx_q]) begin
            pin_d[in_idx_q] = in_lvl_q ^ invert_q[in_idx_q];
            do_refresh      = 1'b1;
          end
        end
        ReqNone: begin
        end
        default: begin
        end
      endcase
    end

    drive = (pin_d & dir_d) | ~dir_d;
    moved = (smp_q ^ pin_d) & ~dir_d;
    match = ~(pin_d ^ pol_d);

    drv_d = drv_q;
    smp_d = smp_q;
    raw_d = raw_clr;
    if (do_refresh) begin
      drv_d = drive;
      if (moved != '0) begin
        smp_d = pin_d;
      end
      raw_d = raw_clr | (moved & ~sense_d & (both_d | match)) | (match & sense_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      invert_q    <= '0;
      pin_q       <= '0;
      drv_q       <= '0;
      smp_q       <= '0;
      dir_q       <= '0;
      sense_q     <= '0;
      both_q      <= '0;
      pol_q       <= '0;
      en_q        <= '0;
      raw_q       <= '0;
      alt_q       <= '0;
      pad_q[0]    <= PadDrv2mReset;
      for (int i = 1; i < 8; i++) begin
        pad_q[i] <= '0;
      end
      analog_q    <= '0;
      lock_q      <= 1'b1;
      commit_q    <= CommitReset;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      pin_q    <= pin_d;
      drv_q    <= drv_d;
      smp_q    <= smp_d;
      dir_q    <= dir_d;
      sense_q  <= sense_d;
      both_q   <= both_d;
      pol_q    <= pol_d;
      en_q     <= en_d;
      raw_q    <= raw_d;
      alt_q    <= alt_d;
      pad_q    <= pad_d;
      analog_q <= analog_d;
      lock_q   <= lock_d;
      commit_q <= commit_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q   <= req_e'(s_axis_tuser);
      in_off_q   <= s_axis_tdata[11:0];
      in_wdata_q <= s_axis_tdata[43:12];
      in_idx_q   <= s_axis_tdata[46:44];
      in_lvl_q   <= s_axis_tdata[47];
    end
    if (proc) begin
      out_rdata_q <= rdata;
      out_err_q   <= err;
      out_pins_q  <= drv_d;
      out_irq_q   <= |(raw_d & en_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_irq_q, out_pins_q, out_rdata_q};
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire

// File: dv/gpio_controller_with_interrupts_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_controller_with_interrupts_tb
// Streams bus reads, bus writes and pin level events into the GPIO controller
// under random source gaps and sink stalls. A behavioral copy of the register
// file and interrupt logic predicts every result, which is checked field by
// field. The input inversion register is changed between idle phases.
// ----------------------------------------------------------------------------

module gpio_controller_with_interrupts_tb;
  import gpioc_pkg::*;

  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned CycleLimit    = 400000;

  // ID bytes, word 0 in the low byte
  localparam logic [95:0] IdBytes = {8'hB1, 8'h05, 8'hF0, 8'h0D, 8'h00, 8'h04,
                                     8'h10, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    req_e        kind;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic [2:0]  line;
    logic        level;
  } gpio_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bus_error;
    logic [7:0] out_pins;
    logic       irq;
  } gpio_rsp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // offset, write_data, pin_index, pin_level
  logic [1:0]  s_axis_tuser  = '0;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // read_data, out_pins, irq_line, zero fill
  logic [0:0]  m_axis_tuser;         // bus_error

  gpio_controller_with_interrupts i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted controller state
  logic [7:0] invert;
  logic [7:0] pins, driven, sampled, dir, sense, both_edge, polarity, irq_en;
  logic [7:0] raw, afsel, commit;
  logic [7:0] pad [10];
  logic       locked;

  gpio_req_t   pending_q [$];
  gpio_rsp_t   response_q [$];
  int unsigned queued_count  = 0;
  int unsigned checked_count = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  logic        req_taken = 1'b0;
  logic        rsp_taken = 1'b0;
  int unsigned tx_wait   = 0;
  int unsigned tx_quiet  = 0;
  int unsigned rx_wait   = 0;
  int unsigned rx_quiet  = 0;
  gpio_req_t   next_req;
  gpio_req_t   seen_req;
  gpio_rsp_t   want;

  function automatic void refresh_lines();
    logic [7:0] moved, hit;
    moved = (sampled ^ pins) & ~dir;
    hit   = ~(pins ^ polarity);
    driven = (pins & dir) | ~dir;
    if (moved != 0) begin
      sampled = pins;
      raw |= moved & ~sense & (both_edge | hit);
    end
    raw |= hit & sense;
  endfunction

  function automatic gpio_rsp_t apply_request(input gpio_req_t rq);
    gpio_rsp_t  rsp;
    logic [9:0] word;
    logic [7:0] b, m;
    logic       ok, lvl;
    int         idx;
    rsp  = '0;
    word = rq.offset[11:2];
    b    = rq.wdata[7:0];
    ok   = 1'b1;
    case (rq.kind)
      ReqRead: begin
        if (word >= WordIdBase) begin
          idx = int'(word - WordIdBase);
          rsp.read_data = IdBytes[idx*8 +: 8];
        end else if (word < WordDir) begin
          rsp.read_data = pins & rq.offset[9:2];
        end else if (word >= WordPadLo && word <= WordPadHi) begin
          rsp.read_data = pad[word - WordPadLo];
        end else begin
          case (word)
            WordDir:     rsp.read_data = dir;
            WordSense:   rsp.read_data = sense;
            WordBoth:    rsp.read_data = both_edge;
            WordEvent:   rsp.read_data = polarity;
            WordMask:    rsp.read_data = irq_en;
            WordRaw:     rsp.read_data = raw;
            WordMasked:  rsp.read_data = raw & irq_en;
            WordAltFunc: rsp.read_data = afsel;
            WordLock:    rsp.read_data = {7'd0, locked};
            WordCommit:  rsp.read_data = commit;
            WordAnalog:  rsp.read_data = pad[8];
            default:     ok = 1'b0;
          endcase
        end
      end
      ReqWrite: begin
        if (word < WordDir) begin
          // only lines set as outputs take the written bits
          m = rq.offset[9:2] & dir;
          pins = (pins & ~m) | (b & m);
        end else if (word >= WordPadLo && word <= WordPadHi) begin
          pad[word - WordPadLo] = b;
        end else begin
          case (word)
            WordDir:     dir = b;
            WordSense:   sense = b;
            WordBoth:    both_edge = b;
            WordEvent:   polarity = b;
            WordMask:    irq_en = b;
            WordClear:   raw &= ~b;
            WordAltFunc: afsel = (afsel & ~commit) | (b & commit);
            WordLock:    locked = (rq.wdata != UnlockKey);
            WordCommit:  if (!locked) commit = b;
            WordAnalog:  pad[8] = b;
            default:     ok = 1'b0;
          endcase
        end
        if (ok) refresh_lines();
      end
      ReqPin: begin
        lvl = rq.level ^ invert[rq.line];
        if (!dir[rq.line]) begin
          pins[rq.line] = lvl;
          refresh_lines();
        end
      end
      default: ;
    endcase
    rsp.bus_error = !ok;
    if (!ok) rsp.read_data = '0;
    rsp.out_pins = driven;
    rsp.irq      = |(raw & irq_en);
    return rsp;
  endfunction

  // Count down a no-idle stretch, or start one now and then
  function automatic int unsigned next_quiet(input int unsigned q);
    if (q != 0) return q - 1;
    return ($urandom_range(0, 24) == 0) ? $urandom_range(8, 40) : 0;
  endfunction

  function automatic int unsigned draw_pause(input int unsigned q);
    return (q != 0) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [11:0] reg_off(input logic [9:0] w);
    return {w, 2'b00};
  endfunction

  function automatic logic [11:0] pick_offset();
    logic [9:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2:       w = 10'($urandom_range(0, 255));
      3, 4, 5, 6:    w = WordDir + 10'($urandom_range(0, 8));
      7, 8:          w = WordPadLo + 10'($urandom_range(0, 10));
      default:       w = WordIdBase + 10'($urandom_range(0, 11));
    endcase
    return {w, 2'($urandom)};
  endfunction

  function automatic void check_field(input string what, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %h got %h", $time, what, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic push_req(input req_e k, input logic [11:0] off, input logic [31:0] wd,
                          input logic [2:0] ln, input logic lv);
    gpio_req_t rq;
    rq.kind   = k;
    rq.offset = off;
    rq.wdata  = wd;
    rq.line   = ln;
    rq.level  = lv;
    pending_q.push_back(rq);
    queued_count++;
  endtask

  task automatic push_random();
    int unsigned r;
    logic [11:0] off;
    logic [31:0] wd;
    r   = $urandom_range(0, 99);
    off = pick_offset();
    wd  = $urandom;
    if (off[11:2] == WordLock && $urandom_range(0, 1) == 1) wd = UnlockKey;
    if (r < 35)
      push_req(ReqPin, 12'($urandom), $urandom, 3'($urandom), 1'($urandom));
    else if (r < 65)
      push_req(ReqWrite, off, wd, 3'($urandom), 1'($urandom));
    else if (r < 90)
      push_req(ReqRead, off, wd, 3'($urandom), 1'($urandom));
    else
      push_req(req_e'($urandom_range(0, 3)), 12'($urandom), $urandom, 3'($urandom),
               1'($urandom));
  endtask

  task automatic write_invert(input logic [7:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    invert = v;
  endtask

  task automatic wait_drained();
    while (checked_count != queued_count) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Source side: hold until transfer, then pause, then present the next item
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !req_taken) begin
        // hold
      end else if (tx_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        tx_wait--;
      end else if (pending_q.size() != 0) begin
        next_req = pending_q.pop_front();
        s_axis_tuser  <= next_req.kind;
        s_axis_tdata  <= {next_req.level, next_req.line, next_req.wdata, next_req.offset};
        s_axis_tvalid <= 1'b1;
        tx_quiet = next_quiet(tx_quiet);
        tx_wait  = draw_pause(tx_quiet);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: stall a random number of cycles after each result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) begin
        rx_quiet = next_quiet(rx_quiet);
        rx_wait  = draw_pause(rx_quiet);
      end
      if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    req_taken   <= s_axis_tvalid && s_axis_tready;
    rsp_taken   <= m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen_req.kind   = req_e'(s_axis_tuser);
      seen_req.offset = s_axis_tdata[11:0];
      seen_req.wdata  = s_axis_tdata[43:12];
      seen_req.line   = s_axis_tdata[46:44];
      seen_req.level  = s_axis_tdata[47];
      response_q.push_back(apply_request(seen_req));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (response_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = response_q.pop_front();
        check_field("read_data", want.read_data, m_axis_tdata[7:0]);
        check_field("bus_error", {7'd0, want.bus_error}, {7'd0, m_axis_tuser[0]});
        check_field("out_pins", want.out_pins, m_axis_tdata[15:8]);
        check_field("irq_line", {7'd0, want.irq}, {7'd0, m_axis_tdata[16]});
        checked_count++;
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin
    invert = '0; pins = '0; driven = '0; sampled = '0; dir = '0; sense = '0;
    both_edge = '0; polarity = '0; irq_en = '0; raw = '0; afsel = '0;
    for (int i = 0; i < 10; i++) pad[i] = '0;
    pad[0] = '1;
    commit = '1;
    locked = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_invert(8'h80);
    @(posedge clk_i);
    push_req(ReqRead, 12'hFD0, '0, 3'd0, 1'b0);
    push_req(ReqRead, 12'hFFF, '1, 3'd7, 1'b1);
    push_req(ReqNone, 12'hFFF, '1, 3'd7, 1'b1);     // out_pins still zero here
    push_req(ReqRead, reg_off(WordLock) + 12'd1, '0, 3'd0, 1'b0);
    push_req(ReqRead, 12'h000, '0, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordDir), 32'h0000_000F, 3'd0, 1'b0);
    push_req(ReqWrite, 12'h3FC, '1, 3'd0, 1'b0);
    push_req(ReqRead, 12'h3FC, '0, 3'd0, 1'b0);
    push_req(ReqPin, 12'h000, '0, 3'd7, 1'b1);      // inverted line
    push_req(ReqPin, 12'h000, '0, 3'd0, 1'b1);      // output line, ignored
    push_req(ReqWrite, reg_off(WordSense), 32'h0000_0080, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordEvent), 32'h0000_00FF, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordBoth), 32'h0000_0040, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordMask), 32'h0000_00FF, 3'd0, 1'b0);
    push_req(ReqPin, 12'h000, '0, 3'd6, 1'b1);
    push_req(ReqRead, reg_off(WordMasked), '0, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordRaw), '1, 3'd0, 1'b0);      // read only
    push_req(ReqRead, reg_off(WordClear), '0, 3'd0, 1'b0);     // write only
    push_req(ReqWrite, reg_off(WordClear), '1, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordLock), UnlockKey, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordCommit), 32'h0000_000F, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordAltFunc), 32'h0000_00FF, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordLock), '0, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordCommit), 32'h0000_00FF, 3'd0, 1'b0);  // locked
    push_req(ReqRead, reg_off(WordAltFunc), '0, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordPadHi), 32'h0000_00A5, 3'd0, 1'b0);
    push_req(ReqWrite, reg_off(WordAnalog), 32'h0000_003C, 3'd0, 1'b0);
    push_req(ReqRead, reg_off(WordAnalog) + 12'd4, '0, 3'd0, 1'b0);     // unmapped
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       write_invert(8'hFF);
        1:       write_invert(8'h00);
        2:       write_invert(8'hA5);
        default: write_invert(8'($urandom));
      endcase
      @(posedge clk_i);
      for (int n = 0; n < ItemsPerPhase; n++) push_random();
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && response_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
